@@ hw/rtl/quaternion_pose_to_model_matrix_top_assert.svh @@
// Assertion macros for the pose to model matrix block.
`ifndef QUATERNION_POSE_TO_MODEL_MATRIX_TOP_ASSERT_SVH
`define QUATERNION_POSE_TO_MODEL_MATRIX_TOP_ASSERT_SVH

// same-cycle implication
`define QP2M_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QP2M_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/qp2m_pkg.sv @@
// Package: formats, widths and bundle types of the pose to model matrix block.
package qp2m_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW        = 24;
  localparam int PW        = 32;
  localparam int PRD_W     = 2 * QW;
  localparam int SW        = 2 * QW + 1;
  localparam int NUM_W     = SW + 1;
  localparam int MAG_W     = SW;
  localparam int REM_W     = SW + 1;
  localparam int Q_W       = FRAC_BITS + 2;
  localparam int DIV_LAT   = FRAC_BITS + 2;
  localparam int R_W       = Q_W + 1;
  localparam int P_W       = R_W + QW;
  localparam int IN_W      = 3 * PW + 7 * QW;
  localparam int OUT_W     = 9 * QW + 3 * PW;

  localparam logic [63:0] SQ_EPS64 = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;
  localparam logic [SW-1:0] SQ_EPS  = SQ_EPS64[SW-1:0];
  localparam logic [SW-1:0] ONE_2F  = SW'(64'd1 << (2 * FRAC_BITS));
  localparam logic [Q_W-1:0] Q_MAX  = Q_W'(64'd1 << (FRAC_BITS + 1));

  typedef struct packed {
    logic [2:0][QW-1:0] scale;
    logic [2:0][PW-1:0] pos;
  } carry_t;

  typedef struct packed {
    logic                tiny;
    logic [8:0]          neg;
    logic [8:0][Q_W-1:0] rt;
    carry_t              cr;
  } side_t;

endpackage

@@ hw/rtl/quaternion_pose_to_model_matrix_top.sv @@
// Top level: pose (position, quaternion, scale) to scaled rotation and translation rows.
// One item per clock while the output is not stalled; most of the
// depth is set by the restoring divider, one quotient bit per stage, nine lanes wide.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
// Quaternion with squared norm at or below 1e-8 is used raw with factor 2.
module quaternion_pose_to_model_matrix_top import qp2m_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, trans_x, trans_y, trans_z
  output logic [OUT_W-1:0] out_tdata
);

  localparam logic signed [P_W-1:0] HALF    = P_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [P_W-1:0] SAT_MAX = P_W'(64'd8388607);
  localparam logic signed [P_W-1:0] SAT_MIN = -P_W'(64'd8388608);

  logic ce;
  logic out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;

  assign ce         = !out_tvalid_r || out_tready;
  assign in_tready  = ce;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // stage A: products
  logic va_r;
  logic signed [PRD_W-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  carry_t cra_r;
  logic signed [QW-1:0] qx, qy, qz, qw;
  carry_t cr_in;

  always_comb begin
    qx = in_tdata[96 +: QW];
    qy = in_tdata[120 +: QW];
    qz = in_tdata[144 +: QW];
    qw = in_tdata[168 +: QW];
    for (int i = 0; i < 3; i++) begin
      cr_in.pos[i]   = in_tdata[i*PW +: PW];
      cr_in.scale[i] = in_tdata[192 + i*QW +: QW];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      xx_r <= PRD_W'(qx) * PRD_W'(qx);
      yy_r <= PRD_W'(qy) * PRD_W'(qy);
      zz_r <= PRD_W'(qz) * PRD_W'(qz);
      ww_r <= PRD_W'(qw) * PRD_W'(qw);
      xy_r <= PRD_W'(qx) * PRD_W'(qy);
      xz_r <= PRD_W'(qx) * PRD_W'(qz);
      yz_r <= PRD_W'(qy) * PRD_W'(qz);
      wx_r <= PRD_W'(qw) * PRD_W'(qx);
      wy_r <= PRD_W'(qw) * PRD_W'(qy);
      wz_r <= PRD_W'(qw) * PRD_W'(qz);
      cra_r <= cr_in;
    end
  end

  // stage B: norm, pair sums, off-diagonal numerators
  logic vb_r;
  logic [SW-1:0] sb_r;
  logic signed [SW-1:0] pd_r [3];
  logic signed [NUM_W-1:0] off_r [9];
  carry_t crb_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      sb_r <= SW'(xx_r[PRD_W-2:0]) + SW'(yy_r[PRD_W-2:0])
            + SW'(zz_r[PRD_W-2:0]) + SW'(ww_r[PRD_W-2:0]);
      pd_r[0] <= SW'(yy_r) + SW'(zz_r);
      pd_r[1] <= SW'(xx_r) + SW'(zz_r);
      pd_r[2] <= SW'(xx_r) + SW'(yy_r);
      off_r[1] <= (NUM_W'(xy_r) - NUM_W'(wz_r)) <<< 1;
      off_r[2] <= (NUM_W'(xz_r) + NUM_W'(wy_r)) <<< 1;
      off_r[3] <= (NUM_W'(xy_r) + NUM_W'(wz_r)) <<< 1;
      off_r[5] <= (NUM_W'(yz_r) - NUM_W'(wx_r)) <<< 1;
      off_r[6] <= (NUM_W'(xz_r) - NUM_W'(wy_r)) <<< 1;
      off_r[7] <= (NUM_W'(yz_r) + NUM_W'(wx_r)) <<< 1;
      off_r[0] <= '0;
      off_r[4] <= '0;
      off_r[8] <= '0;
      crb_r <= cra_r;
    end
  end

  // stage C: tiny test and diagonal numerators
  logic vc_r;
  logic tc_r;
  logic [SW-1:0] sc_r;
  logic signed [NUM_W-1:0] num_r [9];
  carry_t crc_r;
  logic tiny_c;
  logic [SW-1:0] one_c;

  always_comb begin
    tiny_c = sb_r <= SQ_EPS;
    one_c  = tiny_c ? ONE_2F : sb_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      tc_r <= tiny_c;
      sc_r <= sb_r;
      for (int i = 0; i < 9; i++) begin
        if (i == 0 || i == 4 || i == 8) begin
          num_r[i] <= $signed({1'b0, one_c}) - (NUM_W'(pd_r[i/4]) <<< 1);
        end else begin
          num_r[i] <= off_r[i];
        end
      end
      crc_r <= crb_r;
    end
  end

  // stage D: sign and magnitude, small-norm rounding
  logic vd_r;
  logic [SW-1:0] sd_r;
  logic [MAG_W-1:0] mag_r [9];
  side_t sided_r;
  logic [NUM_W-1:0] neg_num [9];
  logic [MAG_W-1:0] mag_c [9];
  logic [MAG_W-1:0] rsum [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      neg_num[i] = -num_r[i];
      mag_c[i]   = num_r[i][NUM_W-1] ? neg_num[i][MAG_W-1:0] : num_r[i][MAG_W-1:0];
      rsum[i]    = mag_c[i] + MAG_W'(64'd1 << (FRAC_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sd_r         <= sc_r;
      sided_r.tiny <= tc_r;
      sided_r.cr   <= crc_r;
      for (int i = 0; i < 9; i++) begin
        mag_r[i]       <= mag_c[i];
        sided_r.neg[i] <= num_r[i][NUM_W-1];
        sided_r.rt[i]  <= rsum[i][FRAC_BITS +: Q_W];
      end
    end
  end

  // divider lanes and matching side delay line
  logic [Q_W-1:0] quo [9];
  side_t side_r [DIV_LAT];
  logic vdv_r [DIV_LAT];

  for (genvar g = 0; g < 9; g++) begin : g_lane
    qp2m_div_lane u_lane (
      .clk (clk),
      .en  (ce),
      .mag (mag_r[g]),
      .den (sd_r),
      .quo (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side_r[0] <= sided_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // stage E: rounded ratio with sign
  logic ve_r;
  logic signed [R_W-1:0] r_r [9];
  carry_t cre_r;
  side_t st;
  logic [Q_W:0] qp1 [9];
  logic [Q_W-1:0] msel [9];

  always_comb begin
    st = side_r[DIV_LAT-1];
    for (int i = 0; i < 9; i++) begin
      qp1[i]  = {1'b0, quo[i]} + (Q_W+1)'(1);
      msel[i] = st.tiny ? st.rt[i] : qp1[i][Q_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cre_r <= st.cr;
      for (int i = 0; i < 9; i++) begin
        r_r[i] <= st.neg[i] ? -$signed({1'b0, msel[i]}) : $signed({1'b0, msel[i]});
      end
    end
  end

  // stage F: scale products
  logic vf_r;
  logic signed [P_W-1:0] p_r [9];
  logic [2:0][PW-1:0] posf_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      posf_r <= cre_r.pos;
      for (int i = 0; i < 9; i++) begin
        p_r[i] <= P_W'(r_r[i]) * P_W'($signed(cre_r.scale[i%3]));
      end
    end
  end

  // stage G: round, saturate, pack
  logic signed [P_W-1:0] tr [9];
  logic signed [P_W-1:0] shv [9];
  logic [OUT_W-1:0] out_c;

  always_comb begin
    out_c = '0;
    for (int i = 0; i < 9; i++) begin
      tr[i]  = p_r[i][P_W-1] ? p_r[i] + HALF - P_W'(1) : p_r[i] + HALF;
      shv[i] = tr[i] >>> FRAC_BITS;
      if (shv[i] > SAT_MAX) begin
        out_c[i*QW +: QW] = SAT_MAX[QW-1:0];
      end else if (shv[i] < SAT_MIN) begin
        out_c[i*QW +: QW] = SAT_MIN[QW-1:0];
      end else begin
        out_c[i*QW +: QW] = shv[i][QW-1:0];
      end
    end
    for (int i = 0; i < 3; i++) begin
      out_c[9*QW + i*PW +: PW] = posf_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_tdata_r <= out_c;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) begin
        vdv_r[k] <= 1'b0;
      end
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (ce) begin
      va_r <= in_tvalid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      vdv_r[0] <= vd_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        vdv_r[k] <= vdv_r[k-1];
      end
      ve_r <= vdv_r[DIV_LAT-1];
      vf_r <= ve_r;
      out_tvalid_r <= vf_r;
    end
  end

  logic q_over;
  always_comb begin
    q_over = 1'b0;
    for (int i = 0; i < 9; i++) begin
      q_over = q_over || (quo[i] > Q_MAX);
    end
  end

`include "quaternion_pose_to_model_matrix_top_assert.svh"

  `QP2M_ASSERT_IMPLY(a_quo_bound, vdv_r[DIV_LAT-1] && !st.tiny, !q_over, "quotient out of range")
  `QP2M_ASSERT_NEXT(a_last_adv, ce && vf_r, out_tvalid_r, "item lost at output stage")
  `QP2M_ASSERT_NEXT(a_frozen, !ce, $stable(ve_r) && $stable(vf_r), "pipeline moved on stall")

endmodule

@@ hw/rtl/qp2m_div_lane.sv @@
// One lane of the pipelined restoring divider: floor(mag * 2^(F+1) / den), mag <= den.
module qp2m_div_lane import qp2m_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [MAG_W-1:0] mag,
  input  logic [SW-1:0]    den,
  output logic [Q_W-1:0]   quo
);

  logic [SW-1:0]  rem_r [DIV_LAT-1];
  logic [SW-1:0]  d_r   [DIV_LAT-1];
  logic [Q_W-1:0] q_r   [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= den;
      if (mag >= den) begin
        rem_r[0] <= mag - den;
        q_r[0]   <= Q_W'(1);
      end else begin
        rem_r[0] <= mag;
        q_r[0]   <= '0;
      end
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
    logic [REM_W-1:0] sh;
    logic             ge;
    assign sh = {rem_r[k-1], 1'b0};
    assign ge = sh >= {1'b0, d_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= {q_r[k-1][Q_W-2:0], ge};
      end
    end
    if (k < DIV_LAT - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          d_r[k]   <= d_r[k-1];
          rem_r[k] <= ge ? SW'(sh - {1'b0, d_r[k-1]}) : sh[SW-1:0];
        end
      end
    end
  end

  assign quo = q_r[DIV_LAT-1];

endmodule
